[sv/ssm_pkg.sv]
// shared types and constants for the sorted set merge block
package ssm_pkg;

  localparam int DATA_W             = 32;
  localparam int DEFAULT_LIST_DEPTH = 32;

  typedef enum logic [1:0] {
    OP_APPEND_A = 2'd0,
    OP_APPEND_B = 2'd1,
    OP_RUN      = 2'd2,
    OP_UNUSED   = 2'd3
  } ssm_op_t;

  localparam logic MODE_INTERSECT = 1'b0;
  localparam logic MODE_UNION     = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic app_a;   // write element into list a
    logic app_b;   // write element into list b
    logic step;    // advance the merge walk by one step
    logic finish;  // emit final item and clear lists
  } ssm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk_done;   // walk over: either cursor exhausted (intersect) or both (union)
    logic can_step;    // room to take the result of a step
    logic can_finish;  // output register free for the final item
  } ssm_status_t;

endpackage

[sv/ssm_datapath.sv]
// list stores, merge cursors, compare logic and output register
module ssm_datapath #(
  parameter int LIST_DEPTH = ssm_pkg::DEFAULT_LIST_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ssm_pkg::ssm_cmd_t                 cmd,
  output ssm_pkg::ssm_status_t              status,
  input  logic                              cfg_write_en,
  input  logic                              cfg_write_data,
  input  logic signed [ssm_pkg::DATA_W-1:0] element_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [ssm_pkg::DATA_W-1:0] result_value,
  output logic                              value_present,
  output logic                              last_of_run,
  output logic                              overflow_seen
);
  import ssm_pkg::*;

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

  logic signed [DATA_W-1:0] mem_a [0:LIST_DEPTH-1];
  logic signed [DATA_W-1:0] mem_b [0:LIST_DEPTH-1];

  logic [CW-1:0] count_a, count_b;
  logic [CW-1:0] ia, ib, ia_next, ib_next;
  logic [AW-1:0] raddr_a, raddr_b;
  logic          overflow_flag;
  logic          merge_mode;
  logic signed [DATA_W-1:0] rd_a, rd_b;

  logic                     pend_v;
  logic signed [DATA_W-1:0] pend_val;

  logic                     a_left, b_left, vals_eq, a_lt_b;
  logic                     adv_a, adv_b, step_emit, walk_done;
  logic signed [DATA_W-1:0] emit_val;
  logic                     out_free;

  assign a_left  = (ia < count_a);
  assign b_left  = (ib < count_b);
  assign vals_eq = (rd_a == rd_b);
  assign a_lt_b  = (rd_a < rd_b);

  // one step of the walk
  always_comb begin
    adv_a     = 1'b0;
    adv_b     = 1'b0;
    step_emit = 1'b0;
    emit_val  = rd_a;
    walk_done = 1'b0;
    if (merge_mode == MODE_INTERSECT) begin
      if (a_left && b_left) begin
        if (vals_eq) begin
          adv_a     = 1'b1;
          adv_b     = 1'b1;
          step_emit = 1'b1;
        end else if (a_lt_b) begin
          adv_a = 1'b1;
        end else begin
          adv_b = 1'b1;
        end
      end else begin
        walk_done = 1'b1;
      end
    end else begin
      if (!a_left && !b_left) begin
        walk_done = 1'b1;
      end else if (!a_left) begin
        adv_b     = 1'b1;
        step_emit = 1'b1;
        emit_val  = rd_b;
      end else if (!b_left) begin
        adv_a     = 1'b1;
        step_emit = 1'b1;
      end else if (vals_eq) begin
        adv_a     = 1'b1;
        adv_b     = 1'b1;
        step_emit = 1'b1;
      end else if (a_lt_b) begin
        adv_a     = 1'b1;
        step_emit = 1'b1;
      end else begin
        adv_b     = 1'b1;
        step_emit = 1'b1;
        emit_val  = rd_b;
      end
    end
  end

  assign out_free          = !out_valid || out_ready;
  assign status.walk_done  = walk_done;
  assign status.can_step   = !step_emit || !pend_v || out_free;
  assign status.can_finish = out_free;

  // next cursor values feed the read ports, so read data lines up with the cursors
  always_comb begin
    ia_next = ia;
    ib_next = ib;
    if (cmd.finish) begin
      ia_next = '0;
      ib_next = '0;
    end else if (cmd.step) begin
      ia_next = ia + CW'(adv_a);
      ib_next = ib + CW'(adv_b);
    end
  end

  assign raddr_a = (ia_next < DEPTH_C) ? ia_next[AW-1:0] : '0;
  assign raddr_b = (ib_next < DEPTH_C) ? ib_next[AW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (cmd.app_a && count_a < DEPTH_C) begin
      mem_a[count_a[AW-1:0]] <= element_value;
    end
    if (cmd.app_b && count_b < DEPTH_C) begin
      mem_b[count_b[AW-1:0]] <= element_value;
    end
    rd_a <= mem_a[raddr_a];
    rd_b <= mem_b[raddr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_a       <= '0;
      count_b       <= '0;
      overflow_flag <= 1'b0;
      merge_mode    <= MODE_INTERSECT;
      ia            <= '0;
      ib            <= '0;
      pend_v        <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      ia <= ia_next;
      ib <= ib_next;
      if (cfg_write_en) begin
        merge_mode <= cfg_write_data;
      end
      if (cmd.app_a) begin
        if (count_a < DEPTH_C) begin
          count_a <= count_a + 1'b1;
        end else begin
          overflow_flag <= 1'b1;
        end
      end
      if (cmd.app_b) begin
        if (count_b < DEPTH_C) begin
          count_b <= count_b + 1'b1;
        end else begin
          overflow_flag <= 1'b1;
        end
      end
      if (cmd.step && step_emit) begin
        // hold newest result back until we know whether it is the last
        if (pend_v) begin
          out_valid     <= 1'b1;
          result_value  <= pend_val;
          value_present <= 1'b1;
          last_of_run   <= 1'b0;
          overflow_seen <= overflow_flag;
        end else if (out_ready) begin
          out_valid <= 1'b0;
        end
        pend_v   <= 1'b1;
        pend_val <= emit_val;
      end else if (cmd.finish) begin
        out_valid     <= 1'b1;
        result_value  <= pend_v ? pend_val : '0;
        value_present <= pend_v;
        last_of_run   <= 1'b1;
        overflow_seen <= overflow_flag;
        pend_v        <= 1'b0;
        count_a       <= '0;
        count_b       <= '0;
        overflow_flag <= 1'b0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[sv/ssm_ctrl.sv]
// controller state machine for load and merge walk
module ssm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           opcode,
  input  ssm_pkg::ssm_status_t status,
  output ssm_pkg::ssm_cmd_t    cmd
);
  import ssm_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_t;

  state_t state;
  logic   take;

  assign in_ready = (state == S_IDLE);
  assign take     = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    cmd.app_a  = take && (opcode == OP_APPEND_A);
    cmd.app_b  = take && (opcode == OP_APPEND_B);
    cmd.step   = (state == S_WALK) && !status.walk_done && status.can_step;
    cmd.finish = (state == S_WALK) && status.walk_done && status.can_finish;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (take && opcode == OP_RUN) begin
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (cmd.finish) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[sv/sorted_set_merge_top.sv]
// top level of the sorted set merge block
// Two ascending lists of signed 32-bit values (A and B, LIST_DEPTH entries
// each) load by append transfers, one per cycle when idle; a run transfer
// merges them as an intersection (merge_mode 0) or a union (merge_mode 1).
// Equal values are paired one for one and emitted once per pair. Every run
// ends with exactly one transfer carrying last_of_run; a run with nothing
// to emit gives a single transfer with value_present low. overflow_seen is
// constant across a run and tells whether any append since the previous
// run was dropped on a full list. Appends and opcode 3 give no result.
// After the run transfer the input side stays closed while the walk steps run
// (at most count_a + count_b steps; each step reads one entry of each list and
// moves one or both cursors) and while the final transfer is loaded; it stays
// closed longer when out_ready held low fills the hold stage and the output
// register. No new input transfer is taken while a run walks; the last result
// of one run may still sit in the output register while the next appends
// come in.
module sorted_set_merge_top #(
  parameter int LIST_DEPTH = ssm_pkg::DEFAULT_LIST_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_write_en,
  input  logic                              cfg_write_data,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        opcode,
  input  logic signed [ssm_pkg::DATA_W-1:0] element_value,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [ssm_pkg::DATA_W-1:0] result_value,
  output logic                              value_present,
  output logic                              last_of_run,
  output logic                              overflow_seen
);
  import ssm_pkg::*;

  // commands from controller, status back from datapath
  ssm_cmd_t    cmd;
  ssm_status_t status;

  // sequencing: idle load state and merge walk state
  ssm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .opcode   (opcode),
    .status   (status),
    .cmd      (cmd)
  );

  // list memories, cursors, comparator, one-deep hold stage and output register
  ssm_datapath #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .element_value  (element_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_value   (result_value),
    .value_present  (value_present),
    .last_of_run    (last_of_run),
    .overflow_seen  (overflow_seen)
  );

endmodule
